### rtl/gblf_pkg.sv
package gblf_pkg;

    // Item kinds
    localparam logic [1:0] KIND_SENSE = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    // Move directions
    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_NORTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_OBSTACLE_MAP     = 3'd0;
    localparam logic [2:0] REG_P_FREE_SEEN_FREE = 3'd1;
    localparam logic [2:0] REG_P_FREE_SEEN_WALL = 3'd2;
    localparam logic [2:0] REG_P_WALL_SEEN_WALL = 3'd3;
    localparam logic [2:0] REG_P_WALL_SEEN_FREE = 3'd4;
    localparam logic [2:0] REG_P_INTENDED_MOVE  = 3'd5;
    localparam logic [2:0] REG_P_SIDE_DRIFT     = 3'd6;

    localparam int MAP_BITS = 42;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam logic [MAP_BITS-1:0] RST_OBSTACLE_MAP = 42'd12965191168;
    localparam logic [15:0] RST_P_FREE_SEEN_FREE = 16'd58982;
    localparam logic [15:0] RST_P_FREE_SEEN_WALL = 16'd6554;
    localparam logic [15:0] RST_P_WALL_SEEN_WALL = 16'd55706;
    localparam logic [15:0] RST_P_WALL_SEEN_FREE = 16'd9830;
    localparam logic [15:0] RST_P_INTENDED_MOVE  = 16'd52429;
    localparam logic [15:0] RST_P_SIDE_DRIFT     = 16'd6554;

    // Quotient bits of the divider: results never exceed 1.0 in Q1.16
    localparam int QUO_W = 17;
    localparam int NUM_W = 33;

    typedef struct packed {
        logic [1:0] kind;
        logic       sensed_west;
        logic       sensed_north;
        logic       sensed_east;
        logic       sensed_south;
        logic [1:0] move_dir;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  cell_row;
        logic [2:0]  cell_col;
        logic [15:0] probability;
        logic        last_cell;
    } t_out_item;

endpackage

### rtl/grid_bayes_localization_filter.sv
// Steps: sense runs a likelihood sweep over every cell, then reads each term and runs the
// serial divide of 17 quotient bits to normalize it; move runs one sweep over its source
// cells; initialize counts the free cells, divides once and fills the grid; other kinds
// only stream. Output stream: CELLS beats per item, one per cell, after every kind.
// The filter takes one item at a time; the input stalls until the last beat is taken.
// Reset: synchronous, active low; registers take their defaults and a clearing
// pass zeroes bank 0 of the belief memory before the first item is taken.
module grid_bayes_localization_filter #(
    parameter int GRID_ROWS = 6,
    parameter int GRID_COLS = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  gblf_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output gblf_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gblf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gblf_pkg::MAP_BITS-1:0]         i_cfg_data
);

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ADDR_W = CELL_W + 1;
    localparam int NORM_W = $clog2(CELLS * 65535 + 1);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int MB     = gblf_pkg::MAP_BITS;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_INIT_CNT  = 4'd2;
    localparam logic [3:0] S_INIT_DIV  = 4'd3;
    localparam logic [3:0] S_INIT_WAIT = 4'd4;
    localparam logic [3:0] S_INIT_FILL = 4'd5;
    localparam logic [3:0] S_SWEEP     = 4'd6;
    localparam logic [3:0] S_NORM_RD   = 4'd7;
    localparam logic [3:0] S_NORM_DIV  = 4'd8;
    localparam logic [3:0] S_NORM_WAIT = 4'd9;
    localparam logic [3:0] S_OUT_RD    = 4'd10;
    localparam logic [3:0] S_OUT_LD    = 4'd11;
    localparam logic [3:0] S_OUT_WAIT  = 4'd12;

    localparam logic [2:0] PH_LAST = 3'd6;

    // Configuration registers
    logic [MB-1:0] r_map;
    logic [15:0]   r_pff, r_pfw, r_pww, r_pwf, r_pim, r_psd;

    // Sequencer state
    logic [3:0]        r_state;
    logic [2:0]        r_row, r_col;
    logic [CELL_W-1:0] r_k;
    logic [2:0]        r_ph;
    logic              r_bank;
    logic [1:0]        r_kind;
    logic [3:0]        r_sense;
    logic [1:0]        r_dir;
    logic [NORM_W-1:0] r_norm;
    logic [CNT_W-1:0]  r_cnt;
    logic [15:0]       r_fill;
    logic [31:0]       r_prod;
    logic [33:0]       r_acc;
    gblf_pkg::t_out_item r_out;
    logic              r_out_valid;

    // Belief memory: two banks, current and next, addressed by bank and cell
    logic [15:0]       r_mem [2**ADDR_W];
    logic [15:0]       r_rdata;

    function automatic logic free_at(input logic [MB-1:0] map,
                                     input logic signed [4:0] r,
                                     input logic signed [4:0] c);
        logic [6:0] idx;
        logic       res;
        idx = 7'(r) * 7'(GRID_COLS) + 7'(c);
        if (r < 5'sd0 || r > $signed(5'(GRID_ROWS - 1)) ||
            c < 5'sd0 || c > $signed(5'(GRID_COLS - 1))) begin
            res = 1'b0;
        end else if (idx >= 7'(MB)) begin
            res = 1'b1;
        end else begin
            res = !map[idx[5:0]];
        end
        return res;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic signed [4:0] r,
                                                  input logic signed [4:0] c);
        logic [6:0] idx;
        idx = 7'(r) * 7'(GRID_COLS) + 7'(c);
        return idx[CELL_W-1:0];
    endfunction

    logic                     last_cell;
    logic signed [4:0]        rs, cs, ar, ac;
    logic                     cur_free;
    logic                     w_free, n_free, e_free, s_free;
    logic [15:0]              f0, f1, f2, f3;
    logic                     bh_free, ah_free, sp_free, sm_free;
    logic [CELL_W-1:0]        a_bh, a_sp, a_sm;
    logic [CELL_W-1:0]        mv_addr;
    logic [15:0]              mv_coef;
    logic [CELL_W-1:0]        rd_cell;
    logic                     rd_bank;
    logic [16:0]              prod_rnd;
    logic [15:0]              mul_a, mul_b;
    logic [17:0]              acc_rnd;
    logic [15:0]              wval;
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [15:0]              wdata;
    logic                     div_start, div_done;
    logic [gblf_pkg::NUM_W-1:0] div_num;
    logic [NORM_W-1:0]        div_den;
    logic [gblf_pkg::QUO_W-1:0] div_quo;
    logic [15:0]              quo_sat;
    logic                     in_acc;

    assign last_cell = (r_k == CELL_W'(CELLS - 1));
    assign rs = $signed({2'b00, r_row});
    assign cs = $signed({2'b00, r_col});
    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // Neighbour freedom and sensor factors
    always_comb begin
        cur_free = free_at(r_map, rs, cs);
        w_free   = free_at(r_map, rs, cs - 5'sd1);
        n_free   = free_at(r_map, rs - 5'sd1, cs);
        e_free   = free_at(r_map, rs, cs + 5'sd1);
        s_free   = free_at(r_map, rs + 5'sd1, cs);
        f0 = !w_free ? (r_sense[3] ? r_pww : r_pwf) : (r_sense[3] ? r_pfw : r_pff);
        f1 = !n_free ? (r_sense[2] ? r_pww : r_pwf) : (r_sense[2] ? r_pfw : r_pff);
        f2 = !e_free ? (r_sense[1] ? r_pww : r_pwf) : (r_sense[1] ? r_pfw : r_pff);
        f3 = !s_free ? (r_sense[0] ? r_pww : r_pwf) : (r_sense[0] ? r_pfw : r_pff);
    end

    // Move geometry: cell behind, ahead and the two drift sides
    always_comb begin
        case (r_dir)
            gblf_pkg::DIR_WEST:  begin ar = 5'sd0;  ac = -5'sd1; end
            gblf_pkg::DIR_NORTH: begin ar = -5'sd1; ac = 5'sd0;  end
            gblf_pkg::DIR_EAST:  begin ar = 5'sd0;  ac = 5'sd1;  end
            default:             begin ar = 5'sd1;  ac = 5'sd0;  end
        endcase
        bh_free = free_at(r_map, rs - ar, cs - ac);
        ah_free = free_at(r_map, rs + ar, cs + ac);
        sp_free = free_at(r_map, rs + ac, cs + ar);
        sm_free = free_at(r_map, rs - ac, cs - ar);
        a_bh = bh_free ? cell_of(rs - ar, cs - ac) : r_k;
        a_sp = sp_free ? cell_of(rs + ac, cs + ar) : r_k;
        a_sm = sm_free ? cell_of(rs - ac, cs - ar) : r_k;
        case (r_ph[1:0])
            2'd0:    mv_addr = a_bh;
            2'd1:    mv_addr = r_k;
            2'd2:    mv_addr = a_sp;
            default: mv_addr = a_sm;
        endcase
        case (r_ph)
            3'd1:    mv_coef = bh_free ? r_pim : 16'd0;
            3'd2:    mv_coef = ah_free ? 16'd0 : r_pim;
            3'd3:    mv_coef = r_psd;
            3'd4:    mv_coef = r_psd;
            default: mv_coef = 16'd0;
        endcase
    end

    // Read address: move walks its sources, everything else reads the own cell
    always_comb begin
        rd_cell = r_k;
        if (r_state == S_SWEEP && r_kind == gblf_pkg::KIND_MOVE && r_ph < 3'd4) begin
            rd_cell = mv_addr;
        end
        rd_bank = (r_state == S_NORM_RD) ? !r_bank : r_bank;
    end

    // Shared multiplier operands, rounded write value and saturated quotient
    always_comb begin
        prod_rnd = 17'((33'(r_prod) + 33'd32768) >> 16);
        mul_a = 16'd0;
        mul_b = 16'd0;
        if (r_kind == gblf_pkg::KIND_MOVE) begin
            mul_a = mv_coef;
            mul_b = r_rdata;
        end else begin
            case (r_ph)
                3'd1:    begin mul_a = f0;             mul_b = f1;      end
                3'd2:    begin mul_a = prod_rnd[15:0]; mul_b = f2;      end
                3'd3:    begin mul_a = prod_rnd[15:0]; mul_b = f3;      end
                3'd4:    begin mul_a = prod_rnd[15:0]; mul_b = r_rdata; end
                default: begin mul_a = 16'd0;          mul_b = 16'd0;   end
            endcase
        end
        acc_rnd = 18'((r_acc + 34'd32768) >> 16);
        if (!cur_free) begin
            wval = 16'd0;
        end else if (acc_rnd > 18'd65535) begin
            wval = 16'hFFFF;
        end else begin
            wval = acc_rnd[15:0];
        end
        quo_sat = div_quo[16] ? 16'hFFFF : div_quo[15:0];
    end

    // Memory write port
    always_comb begin
        we    = 1'b0;
        waddr = {r_bank, r_k};
        wdata = 16'd0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
            end
            S_INIT_FILL: begin
                we    = 1'b1;
                wdata = cur_free ? r_fill : 16'd0;
            end
            S_SWEEP: begin
                we    = (r_ph == PH_LAST);
                waddr = {!r_bank, r_k};
                wdata = wval;
            end
            S_NORM_WAIT: begin
                we    = div_done;
                waddr = {!r_bank, r_k};
                wdata = (r_norm == '0) ? 16'd0 : quo_sat;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Divider operands: uniform value or normalized term
    always_comb begin
        div_start = (r_state == S_INIT_DIV) || (r_state == S_NORM_DIV);
        if (r_state == S_INIT_DIV) begin
            div_num = gblf_pkg::NUM_W'(65536) + gblf_pkg::NUM_W'(r_cnt >> 1);
            div_den = NORM_W'(r_cnt);
        end else begin
            div_num = {1'b0, r_rdata, 16'd0} + gblf_pkg::NUM_W'(r_norm >> 1);
            div_den = r_norm;
        end
    end

    gblf_div #(
        .DEN_W (NORM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Belief memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[{rd_bank, rd_cell}];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= gblf_pkg::RST_OBSTACLE_MAP;
            r_pff <= gblf_pkg::RST_P_FREE_SEEN_FREE;
            r_pfw <= gblf_pkg::RST_P_FREE_SEEN_WALL;
            r_pww <= gblf_pkg::RST_P_WALL_SEEN_WALL;
            r_pwf <= gblf_pkg::RST_P_WALL_SEEN_FREE;
            r_pim <= gblf_pkg::RST_P_INTENDED_MOVE;
            r_psd <= gblf_pkg::RST_P_SIDE_DRIFT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gblf_pkg::REG_OBSTACLE_MAP:     r_map <= i_cfg_data;
                gblf_pkg::REG_P_FREE_SEEN_FREE: r_pff <= i_cfg_data[15:0];
                gblf_pkg::REG_P_FREE_SEEN_WALL: r_pfw <= i_cfg_data[15:0];
                gblf_pkg::REG_P_WALL_SEEN_WALL: r_pww <= i_cfg_data[15:0];
                gblf_pkg::REG_P_WALL_SEEN_FREE: r_pwf <= i_cfg_data[15:0];
                gblf_pkg::REG_P_INTENDED_MOVE:  r_pim <= i_cfg_data[15:0];
                gblf_pkg::REG_P_SIDE_DRIFT:     r_psd <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == S_SWEEP) begin
            if (r_ph == 3'd0) begin
                r_acc <= '0;
            end else if ((r_kind == gblf_pkg::KIND_MOVE && r_ph >= 3'd2 && r_ph <= 3'd5) ||
                         (r_kind != gblf_pkg::KIND_MOVE && r_ph == 3'd5)) begin
                r_acc <= r_acc + 34'(r_prod);
            end
        end
        if (in_acc) begin
            r_sense <= {i_in_data.sensed_west, i_in_data.sensed_north,
                        i_in_data.sensed_east, i_in_data.sensed_south};
            r_dir   <= i_in_data.move_dir;
        end
        if (r_state == S_INIT_WAIT && div_done) begin
            r_fill <= (r_cnt == '0) ? 16'd0 : quo_sat;
        end
        if (r_state == S_OUT_LD) begin
            r_out.cell_row    <= r_row;
            r_out.cell_col    <= r_col;
            r_out.probability <= cur_free ? r_rdata : 16'd0;
            r_out.last_cell   <= last_cell;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_ph        <= '0;
            r_bank      <= 1'b0;
            r_kind      <= '0;
            r_norm      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (last_cell) begin
                        r_row <= '0; r_col <= '0; r_k <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + CELL_W'(1);
                        if (r_col == 3'(GRID_COLS - 1)) begin
                            r_col <= '0; r_row <= r_row + 3'd1;
                        end else begin
                            r_col <= r_col + 3'd1;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind <= i_in_data.kind;
                        r_norm <= '0;
                        r_cnt  <= '0;
                        r_ph   <= '0;
                        case (i_in_data.kind)
                            gblf_pkg::KIND_INIT:  r_state <= S_INIT_CNT;
                            gblf_pkg::KIND_SENSE: r_state <= S_SWEEP;
                            gblf_pkg::KIND_MOVE:  r_state <= S_SWEEP;
                            default:              r_state <= S_OUT_RD;
                        endcase
                    end
                end
                S_INIT_CNT, S_INIT_FILL: begin
                    if (r_state == S_INIT_CNT) begin
                        r_cnt <= r_cnt + CNT_W'(cur_free);
                    end
                    if (last_cell) begin
                        r_row <= '0; r_col <= '0; r_k <= '0;
                        r_state <= (r_state == S_INIT_CNT) ? S_INIT_DIV : S_OUT_RD;
                    end else begin
                        r_k <= r_k + CELL_W'(1);
                        if (r_col == 3'(GRID_COLS - 1)) begin
                            r_col <= '0; r_row <= r_row + 3'd1;
                        end else begin
                            r_col <= r_col + 3'd1;
                        end
                    end
                end
                S_INIT_DIV: begin
                    r_state <= S_INIT_WAIT;
                end
                S_INIT_WAIT: begin
                    if (div_done) begin
                        r_state <= S_INIT_FILL;
                    end
                end
                S_SWEEP: begin
                    if (r_ph != PH_LAST) begin
                        r_ph <= r_ph + 3'd1;
                    end else begin
                        r_ph <= '0;
                        if (r_kind != gblf_pkg::KIND_MOVE) begin
                            r_norm <= r_norm + NORM_W'(wval);
                        end
                        if (last_cell) begin
                            r_row <= '0; r_col <= '0; r_k <= '0;
                            if (r_kind == gblf_pkg::KIND_MOVE) begin
                                r_bank  <= !r_bank;
                                r_state <= S_OUT_RD;
                            end else begin
                                r_state <= S_NORM_RD;
                            end
                        end else begin
                            r_k <= r_k + CELL_W'(1);
                            if (r_col == 3'(GRID_COLS - 1)) begin
                                r_col <= '0; r_row <= r_row + 3'd1;
                            end else begin
                                r_col <= r_col + 3'd1;
                            end
                        end
                    end
                end
                S_NORM_RD: begin
                    r_state <= S_NORM_DIV;
                end
                S_NORM_DIV: begin
                    r_state <= S_NORM_WAIT;
                end
                S_NORM_WAIT: begin
                    if (div_done) begin
                        if (last_cell) begin
                            r_row <= '0; r_col <= '0; r_k <= '0;
                            r_bank  <= !r_bank;
                            r_state <= S_OUT_RD;
                        end else begin
                            r_k <= r_k + CELL_W'(1);
                            if (r_col == 3'(GRID_COLS - 1)) begin
                                r_col <= '0; r_row <= r_row + 3'd1;
                            end else begin
                                r_col <= r_col + 3'd1;
                            end
                            r_state <= S_NORM_RD;
                        end
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    // Hold the beat until taken, then fetch the next cell or, after the last, go idle
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (last_cell) begin
                            r_row <= '0; r_col <= '0; r_k <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + CELL_W'(1);
                            if (r_col == 3'(GRID_COLS - 1)) begin
                                r_col <= '0; r_row <= r_row + 3'd1;
                            end else begin
                                r_col <= r_col + 3'd1;
                            end
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/gblf_div.sv
module gblf_div #(
    parameter int DEN_W = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gblf_pkg::NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_done,
    output logic [gblf_pkg::QUO_W-1:0]  o_quo
);

    localparam int QW  = gblf_pkg::QUO_W;
    localparam int CW  = $clog2(QW + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_q;
    logic [CW-1:0]    r_cnt;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next numerator bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Load on start, then one quotient bit a cycle; numerator below den * 2^QW
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num >> QW);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

### rtl/gblf_check.sv
module gblf_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input gblf_pkg::t_in_item             i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input gblf_pkg::t_out_item            o_out_data,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [gblf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [gblf_pkg::MAP_BITS-1:0]  i_cfg_data
);

    // No new item while a result beat is pending
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result beat is pending");

    // An accepted item closes the input at once
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an item was taken");

    // The final cell ends the stream
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_cell) |=> !o_out_valid)
        else $error("beat after the final cell");

    // A stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

endmodule

bind grid_bayes_localization_filter gblf_check u_gblf_check (.*);

### tb/grid_bayes_localization_filter_tb.sv
module grid_bayes_localization_filter_tb;

    localparam int ROWS = 6;
    localparam int COLS = 7;
    localparam int NCELLS = ROWS * COLS;
    localparam int MB = gblf_pkg::MAP_BITS;
    localparam int IW = gblf_pkg::CFG_IDX_W;
    localparam logic [1:0] KIND_HOLD = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 60;

    // Belief tracker: mirrors the filter state and keeps the cell beats still owed
    class belief_tracker;
        logic [MB-1:0] obstacles;
        logic [15:0] pff, pfw, pww, pwf, pmove, pdrift;
        logic [15:0] belief [NCELLS];
        gblf_pkg::t_out_item owed_cells [$];
        int          fails;

        function void clear();
            obstacles = gblf_pkg::RST_OBSTACLE_MAP;
            pff = gblf_pkg::RST_P_FREE_SEEN_FREE;
            pfw = gblf_pkg::RST_P_FREE_SEEN_WALL;
            pww = gblf_pkg::RST_P_WALL_SEEN_WALL;
            pwf = gblf_pkg::RST_P_WALL_SEEN_FREE;
            pmove = gblf_pkg::RST_P_INTENDED_MOVE;
            pdrift = gblf_pkg::RST_P_SIDE_DRIFT;
            foreach (belief[k]) belief[k] = '0;
            owed_cells.delete();
            fails = 0;
        endfunction

        function void write_reg(logic [IW-1:0] idx, logic [MB-1:0] val);
            case (idx)
                gblf_pkg::REG_OBSTACLE_MAP:     obstacles = val;
                gblf_pkg::REG_P_FREE_SEEN_FREE: pff = val[15:0];
                gblf_pkg::REG_P_FREE_SEEN_WALL: pfw = val[15:0];
                gblf_pkg::REG_P_WALL_SEEN_WALL: pww = val[15:0];
                gblf_pkg::REG_P_WALL_SEEN_FREE: pwf = val[15:0];
                gblf_pkg::REG_P_INTENDED_MOVE:  pmove = val[15:0];
                gblf_pkg::REG_P_SIDE_DRIFT:     pdrift = val[15:0];
                default: ;
            endcase
        endfunction

        function bit open_cell(int r, int c);
            if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 0;
            return obstacles[r * COLS + c] == 1'b0;
        endfunction

        function longint unsigned rmul(longint unsigned a, longint unsigned b);
            return (a * b + 32768) >> 16;
        endfunction

        function longint unsigned side_prob(bit wall, bit seen);
            if (wall) return seen ? pww : pwf;
            return seen ? pfw : pff;
        endfunction

        function void sense(gblf_pkg::t_in_item it);
            longint unsigned l, q;
            logic [15:0] term [NCELLS];
            logic [31:0] norm;
            int k;
            norm = '0;
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++) begin
                    k = r * COLS + c;
                    term[k] = '0;
                    if (open_cell(r, c)) begin
                        l = side_prob(!open_cell(r, c - 1), it.sensed_west);
                        l = rmul(l, side_prob(!open_cell(r - 1, c), it.sensed_north));
                        l = rmul(l, side_prob(!open_cell(r, c + 1), it.sensed_east));
                        l = rmul(l, side_prob(!open_cell(r + 1, c), it.sensed_south));
                        term[k] = 16'(rmul(belief[k], 16'(l)));
                        norm += term[k];
                    end
                end
            for (k = 0; k < NCELLS; k++) begin
                q = 0;
                if (norm != 0) begin
                    q = (longint'(term[k]) * 65536 + norm / 2) / norm;
                    if (q > 65535) q = 65535;
                end
                belief[k] = 16'(q);
            end
        endfunction

        function void move(logic [1:0] dir);
            int dr, dc, pr, pc, k;
            longint unsigned acc;
            logic [15:0] moved [NCELLS];
            dr = (dir == gblf_pkg::DIR_NORTH) ? -1 : (dir == gblf_pkg::DIR_SOUTH) ? 1 : 0;
            dc = (dir == gblf_pkg::DIR_WEST) ? -1 : (dir == gblf_pkg::DIR_EAST) ? 1 : 0;
            pr = dc;
            pc = dr;
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++) begin
                    k = r * COLS + c;
                    moved[k] = '0;
                    if (open_cell(r, c)) begin
                        acc = 0;
                        if (open_cell(r - dr, c - dc))
                            acc += longint'(pmove) * belief[(r - dr) * COLS + c - dc];
                        if (!open_cell(r + dr, c + dc))
                            acc += longint'(pmove) * belief[k];
                        if (open_cell(r + pr, c + pc))
                            acc += longint'(pdrift) * belief[(r + pr) * COLS + c + pc];
                        else
                            acc += longint'(pdrift) * belief[k];
                        if (open_cell(r - pr, c - pc))
                            acc += longint'(pdrift) * belief[(r - pr) * COLS + c - pc];
                        else
                            acc += longint'(pdrift) * belief[k];
                        acc = (acc + 32768) >> 16;
                        if (acc > 65535) acc = 65535;
                        moved[k] = 16'(acc);
                    end
                end
            belief = moved;
        endfunction

        function void spread();
            int cnt;
            longint unsigned v;
            cnt = 0;
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    if (open_cell(r, c)) cnt++;
            v = 0;
            if (cnt != 0) begin
                v = (65536 + cnt / 2) / cnt;
                if (v > 65535) v = 65535;
            end
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    belief[r * COLS + c] = open_cell(r, c) ? 16'(v) : 16'd0;
        endfunction

        // Update the belief and queue every cell of the grid
        function void note_item(gblf_pkg::t_in_item it);
            gblf_pkg::t_out_item o;
            case (it.kind)
                gblf_pkg::KIND_SENSE: sense(it);
                gblf_pkg::KIND_MOVE:  move(it.move_dir);
                gblf_pkg::KIND_INIT:  spread();
                default: ;
            endcase
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++) begin
                    o.cell_row = 3'(r);
                    o.cell_col = 3'(c);
                    o.probability = open_cell(r, c) ? belief[r * COLS + c] : 16'd0;
                    o.last_cell = (r * COLS + c == NCELLS - 1);
                    owed_cells.push_back(o);
                end
        endfunction

        function void check_beat(gblf_pkg::t_out_item got);
            gblf_pkg::t_out_item exp_cell;
            if (owed_cells.size() == 0) begin
                $error("unexpected cell beat %p", got);
                fails++;
                return;
            end
            exp_cell = owed_cells.pop_front();
            if (got.cell_row !== exp_cell.cell_row) begin
                $error("cell_row: expected %0d, got %0d", exp_cell.cell_row, got.cell_row);
                fails++;
            end
            if (got.cell_col !== exp_cell.cell_col) begin
                $error("cell_col: expected %0d, got %0d", exp_cell.cell_col, got.cell_col);
                fails++;
            end
            if (got.probability !== exp_cell.probability) begin
                $error("probability: expected %0d, got %0d",
                       exp_cell.probability, got.probability);
                fails++;
            end
            if (got.last_cell !== exp_cell.last_cell) begin
                $error("last_cell: expected %0d, got %0d", exp_cell.last_cell, got.last_cell);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    gblf_pkg::t_in_item    i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    gblf_pkg::t_out_item   o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [IW-1:0]         i_cfg_index;
    logic [MB-1:0]         i_cfg_data;

    belief_tracker tracker;
    int send_gap_pct;
    int recv_gap_pct;
    int hold_left;
    int cycle_count;

    grid_bayes_localization_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Stall the output at random, or hold off for a requested stretch
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Check every accepted cell beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_beat(o_out_data);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item; valid stays high after the beat unless a gap follows
    task automatic send_item(gblf_pkg::t_in_item it);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            i_in_data <= gblf_pkg::t_in_item'(8'($urandom));
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(it);
    endtask

    task automatic send_kind(logic [1:0] kind, logic [3:0] sensed, logic [1:0] dir);
        gblf_pkg::t_in_item it;
        it.kind = kind;
        {it.sensed_west, it.sensed_north, it.sensed_east, it.sensed_south} = sensed;
        it.move_dir = dir;
        send_item(it);
    endtask

    // Drop valid and wait until every owed cell has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [IW-1:0] idx, logic [MB-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
    endtask

    function automatic logic [MB-1:0] rand_prob(int style);
        logic [MB-1:0] v;
        v = MB'({$urandom, $urandom});
        if (style == 1) v[15:0] = 16'hFFFF;
        else if (style == 2) v[15:0] = 16'h0000;
        return v;
    endfunction

    // Write the whole register set; style 0 random, 1 full scale, 2 zero
    task automatic write_all(logic [MB-1:0] map, int style);
        write_cfg(gblf_pkg::REG_OBSTACLE_MAP, map);
        write_cfg(gblf_pkg::REG_P_FREE_SEEN_FREE, rand_prob(style));
        write_cfg(gblf_pkg::REG_P_FREE_SEEN_WALL, rand_prob(style));
        write_cfg(gblf_pkg::REG_P_WALL_SEEN_WALL, rand_prob(style));
        write_cfg(gblf_pkg::REG_P_WALL_SEEN_FREE, rand_prob(style));
        write_cfg(gblf_pkg::REG_P_INTENDED_MOVE, rand_prob(style));
        write_cfg(gblf_pkg::REG_P_SIDE_DRIFT, rand_prob(style));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [MB-1:0] rand_map();
        logic [MB-1:0] m;
        m = MB'({$urandom, $urandom}) & MB'({$urandom, $urandom});
        if ($urandom_range(9) == 0) m = '0;
        return m;
    endfunction

    // Mostly sense and move, some re-initialisation and unused kinds
    function automatic gblf_pkg::t_in_item rand_item();
        gblf_pkg::t_in_item it;
        int pick;
        it = gblf_pkg::t_in_item'(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 45) it.kind = gblf_pkg::KIND_SENSE;
        else if (pick < 90) it.kind = gblf_pkg::KIND_MOVE;
        else if (pick < 96) it.kind = gblf_pkg::KIND_INIT;
        else it.kind = KIND_HOLD;
        return it;
    endfunction

    initial begin
        int sent;
        tracker = new();
        tracker.clear();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default registers, zero belief, every kind and direction
        send_kind(KIND_HOLD, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b1111, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_INIT, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b1111, gblf_pkg::DIR_SOUTH);
        send_kind(gblf_pkg::KIND_SENSE, 4'b1010, gblf_pkg::DIR_NORTH);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0101, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0000, gblf_pkg::DIR_NORTH);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0000, gblf_pkg::DIR_EAST);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0000, gblf_pkg::DIR_SOUTH);
        send_kind(KIND_HOLD, 4'b1111, gblf_pkg::DIR_SOUTH);
        drain();

        // Change the map under live beliefs, then full-scale probabilities
        write_all(42'h0F0_0F0F_00F0, 1);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0000, gblf_pkg::DIR_EAST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b0110, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_INIT, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_MOVE, 4'b1111, gblf_pkg::DIR_NORTH);
        send_kind(gblf_pkg::KIND_MOVE, 4'b1111, gblf_pkg::DIR_SOUTH);
        send_kind(gblf_pkg::KIND_SENSE, 4'b1001, gblf_pkg::DIR_EAST);
        drain();

        // No free cell, then zero probabilities giving a zero normaliser
        write_all({MB{1'b1}}, 0);
        send_kind(gblf_pkg::KIND_INIT, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b0000, gblf_pkg::DIR_WEST);
        drain();
        write_all('0, 2);
        send_kind(gblf_pkg::KIND_INIT, 4'b0000, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_SENSE, 4'b0011, gblf_pkg::DIR_WEST);
        send_kind(gblf_pkg::KIND_MOVE, 4'b0000, gblf_pkg::DIR_NORTH);
        drain();

        // Random phases, each with fresh registers and a fresh start
        sent = 0;
        for (int phase = 0; phase < 5; phase++) begin
            write_all(rand_map(), (phase == 4) ? 1 : 0);
            for (int n = 0; n < 77; n++) begin
                if (sent < 128) begin
                    send_gap_pct = 25;
                    recv_gap_pct = 59;
                end else if (sent < 256) begin
                    send_gap_pct = 59;
                    recv_gap_pct = 25;
                end else begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
                if (phase == 0 && n == 5) hold_left = 3000;
                if (n == 0) send_kind(gblf_pkg::KIND_INIT, 4'(n), gblf_pkg::DIR_WEST);
                else send_item(rand_item());
                if (n == 40) drain();
                sent++;
            end
            drain();
        end

        if (tracker.fails == 0 && tracker.owed_cells.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
